@@ rtl/sstf_pkg.sv @@
// Shared constants, types and the character-to-segment encoder of the seven-segment formatter.
`default_nettype none

package sstf_pkg;

   localparam int MAX_DIGITS = 8;
   localparam int MAX_TEXT   = 16;

   localparam int DIG_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
   localparam int TXT_W  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
   localparam int LEN_W  = $clog2(MAX_TEXT + 1);
   localparam int CUR_W  = $clog2(2 * MAX_DIGITS + MAX_TEXT + 4);

   localparam logic [1:0] REQ_TEXT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR  = 2'd1;
   localparam logic [1:0] REQ_ALL_ON = 2'd2;

   localparam logic [3:0] DIGIT_COUNT_RESET = 4'd4;

   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_Z   = 8'h7A;
   localparam logic [7:0] LETTER_BASE = 8'd10;

   localparam logic [7:0] PAT_BLANK  = 8'h00;
   localparam logic [7:0] PAT_ALL_ON = 8'hFF;
   localparam logic [7:0] PAT_DASH   = 8'h40;
   localparam logic [7:0] PAT_PERIOD = 8'h80;
   localparam logic [7:0] PAT_DEGREE = 8'h63;

   localparam logic [7:0] SEG_PATTERNS [36] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
      8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h0E,
      8'h76, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
      8'h3E, 8'h3E, 8'h00, 8'h76, 8'h6E, 8'h5B
   };

   typedef struct packed {
      logic [DCNT_W-1:0] digits;
      logic              common_cathode;
   } cfg_type;

   typedef struct packed {
      logic              go;
      logic [1:0]        kind;
      logic              flag;
      logic [DCNT_W-1:0] start;
   } emit_cmd_type;

   typedef struct packed {
      logic             en;
      logic [DIG_W-1:0] addr;
      logic [7:0]       data;
   } frame_wr_type;

   function automatic logic [7:0] seg_encode(input logic [7:0] c);
      logic [7:0] b;
      b = PAT_BLANK;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         b = SEG_PATTERNS[6'(c - CHAR_ZERO)];
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         b = SEG_PATTERNS[6'(c - CHAR_UC_A + LETTER_BASE)];
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
         b = SEG_PATTERNS[6'(c - CHAR_LC_A + LETTER_BASE)];
      end else if (c == CHAR_DASH) begin
         b = PAT_DASH;
      end else if (c == CHAR_STAR) begin
         b = PAT_DEGREE;
      end else if (c == CHAR_PERIOD) begin
         b = PAT_PERIOD;
      end
      return b;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sstf_csr.sv @@
// Configuration registers behind the APB-style port.
`default_nettype none

module sstf_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [2:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output sstf_pkg::cfg_type    cfg
);
   import sstf_pkg::*;

   logic [3:0] digit_count_ff, digit_count_in;
   logic       common_cathode_ff, common_cathode_in;
   logic       wr;

   always_comb begin
      wr = csr_psel && csr_penable && csr_pwrite;
      digit_count_in    = digit_count_ff;
      common_cathode_in = common_cathode_ff;
      if (wr && !csr_paddr[2]) begin
         digit_count_in = csr_pwdata[3:0];
      end
      if (wr && csr_paddr[2]) begin
         common_cathode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff    <= DIGIT_COUNT_RESET;
         common_cathode_ff <= 1'b1;
      end else begin
         digit_count_ff    <= digit_count_in;
         common_cathode_ff <= common_cathode_in;
      end
   end

   // 0 counts as one digit, anything above the maximum as the maximum
   always_comb begin
      if (digit_count_ff == 4'd0) begin
         cfg.digits = DCNT_W'(1);
      end else if (int'(digit_count_ff) > MAX_DIGITS) begin
         cfg.digits = DCNT_W'(MAX_DIGITS);
      end else begin
         cfg.digits = DCNT_W'(digit_count_ff);
      end
      cfg.common_cathode = common_cathode_ff;
      csr_prdata = csr_paddr[2] ? {31'd0, common_cathode_ff} : {28'd0, digit_count_ff};
      csr_pready = 1'b1;
   end

endmodule

`default_nettype wire

@@ rtl/sstf_core.sv @@
// Text loader and justify walk over the text memory, writing the frame memory.
`default_nettype none

module sstf_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_type,
   input  wire logic [7:0]               req_char_code,
   input  wire logic                     req_last_char,
   input  wire logic [sstf_pkg::DCNT_W-1:0] digits,
   input  wire logic                     emit_busy,
   output sstf_pkg::emit_cmd_type        emit_cmd,
   output sstf_pkg::frame_wr_type        frame_wr
);
   import sstf_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic [7:0] text_mem [MAX_TEXT];

   logic              state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pc_ff, pc_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  scan_len_ff, scan_len_in;
   logic [CUR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              proc_ff, proc_in;
   logic              pend_ff, pend_in;
   logic [7:0]        pend_byte_ff, pend_byte_in;
   logic [DCNT_W-1:0] d_ff, d_in;
   logic [DCNT_W-1:0] start_ff, start_in;
   logic [7:0]        rd_data_ff;
   logic              rd_ok_ff, rd_ok_in;

   logic              accept, mem_we, len_room, is_period, too_long, scan_per;
   logic [LEN_W-1:0]  len_new, pc_new, nonper;
   logic              ovf_new;
   logic [DCNT_W-1:0] start_calc;
   logic [7:0]        scan_ch;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      pc_in        = pc_ff;
      ovf_in       = ovf_ff;
      scan_len_in  = scan_len_ff;
      rd_idx_in    = rd_idx_ff;
      proc_in      = 1'b0;
      pend_in      = pend_ff;
      pend_byte_in = pend_byte_ff;
      d_in         = d_ff;
      start_in     = start_ff;
      rd_ok_in     = rd_ok_ff;
      emit_cmd     = '0;
      frame_wr     = '0;
      mem_we       = 1'b0;

      req_ready = (state_ff == ST_IDLE) && !emit_busy;
      accept    = req_valid && req_ready;

      len_room  = int'(len_ff) < MAX_TEXT;
      is_period = req_char_code == CHAR_PERIOD;
      len_new   = len_room ? len_ff + 1'b1 : len_ff;
      pc_new    = (len_room && is_period) ? pc_ff + 1'b1 : pc_ff;
      ovf_new   = ovf_ff || !len_room;
      nonper    = len_new - pc_new;
      too_long  = ovf_new || (int'(nonper) > int'(digits));
      start_calc = DCNT_W'(int'(digits) - int'(nonper));

      scan_ch  = rd_ok_ff ? rd_data_ff : 8'h00;
      scan_per = rd_ok_ff && (rd_data_ff == CHAR_PERIOD);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_TEXT: begin
                     mem_we = len_room;
                     if (req_last_char) begin
                        len_in = '0;
                        pc_in  = '0;
                        ovf_in = 1'b0;
                        if (too_long || nonper == '0) begin
                           emit_cmd.go    = 1'b1;
                           emit_cmd.kind  = REQ_TEXT;
                           emit_cmd.flag  = too_long;
                           emit_cmd.start = start_calc;
                        end else begin
                           state_in    = ST_SCAN;
                           scan_len_in = len_new;
                           rd_idx_in   = '0;
                           pend_in     = 1'b0;
                           d_in        = start_calc;
                           start_in    = start_calc;
                        end
                     end else begin
                        len_in = len_new;
                        pc_in  = pc_new;
                        ovf_in = ovf_new;
                     end
                  end
                  REQ_CLEAR, REQ_ALL_ON: begin
                     emit_cmd.go   = 1'b1;
                     emit_cmd.kind = req_type;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one character consumed per cycle; a pending byte waits for the next character, which may add its period
            rd_idx_in = rd_idx_ff + 1'b1;
            rd_ok_in  = rd_idx_ff < CUR_W'(scan_len_ff);
            proc_in   = 1'b1;
            if (proc_ff) begin
               if (!pend_ff) begin
                  pend_in      = 1'b1;
                  pend_byte_in = seg_encode(scan_ch);
               end else begin
                  frame_wr.en   = 1'b1;
                  frame_wr.addr = d_ff[DIG_W-1:0];
                  frame_wr.data = scan_per ? (pend_byte_ff | PAT_PERIOD) : pend_byte_ff;
                  d_in          = d_ff + 1'b1;
                  if (scan_per) begin
                     pend_in = 1'b0;
                  end else begin
                     pend_byte_in = seg_encode(scan_ch);
                  end
                  if (d_ff + 1'b1 == digits) begin
                     state_in       = ST_IDLE;
                     proc_in        = 1'b0;
                     emit_cmd.go    = 1'b1;
                     emit_cmd.kind  = REQ_TEXT;
                     emit_cmd.flag  = 1'b0;
                     emit_cmd.start = start_ff;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_mem[len_ff[TXT_W-1:0]] <= req_char_code;
      end
      rd_data_ff <= text_mem[rd_idx_ff[TXT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         pc_ff    <= '0;
         ovf_ff   <= 1'b0;
         proc_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pc_ff    <= pc_in;
         ovf_ff   <= ovf_in;
         proc_ff  <= proc_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_len_ff  <= scan_len_in;
      rd_idx_ff    <= rd_idx_in;
      pend_byte_ff <= pend_byte_in;
      d_ff         <= d_in;
      start_ff     <= start_in;
      rd_ok_ff     <= rd_ok_in;
   end

   a_frame_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      frame_wr.en |-> (d_ff < digits))
      else $error("frame write beyond digit count");

   a_scan_excl_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !emit_busy)
      else $error("scan overlaps frame emission");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      int'(len_ff) <= MAX_TEXT)
      else $error("text length beyond buffer");

endmodule

`default_nettype wire

@@ rtl/sstf_emit.sv @@
// Frame memory and digit word emitter with output register.
`default_nettype none

module sstf_emit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  sstf_pkg::cfg_type           cfg,
   input  sstf_pkg::emit_cmd_type      emit_cmd,
   input  sstf_pkg::frame_wr_type      frame_wr,
   output logic                        emit_busy,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_segment_byte,
   output logic                        rsp_last_digit,
   output logic                        rsp_text_too_long
);
   import sstf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_LD   = 2'd2;

   logic [7:0] frame_mem [MAX_DIGITS];

   logic [1:0]        state_ff, state_in;
   logic [DIG_W-1:0]  e_ff, e_in;
   logic [1:0]        kind_ff, kind_in;
   logic              flag_ff, flag_in;
   logic [DCNT_W-1:0] start_ff, start_in;
   logic [7:0]        rd_data_ff;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              tl_ff, tl_in;
   logic              load;
   logic [7:0]        raw;

   always_comb begin
      state_in = state_ff;
      e_in     = e_ff;
      kind_in  = kind_ff;
      flag_in  = flag_ff;
      start_in = start_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      tl_in    = tl_ff;
      valid_in = valid_ff && !rsp_ready;
      load     = (state_ff == ST_LD) && (!valid_ff || rsp_ready);

      case (kind_ff)
         REQ_CLEAR:  raw = PAT_BLANK;
         REQ_ALL_ON: raw = PAT_ALL_ON;
         default:    raw = (flag_ff || int'(e_ff) < int'(start_ff)) ? PAT_BLANK : rd_data_ff;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (emit_cmd.go) begin
               state_in = ST_RD;
               e_in     = DIG_W'(cfg.digits - 1'b1);
               kind_in  = emit_cmd.kind;
               flag_in  = emit_cmd.flag;
               start_in = emit_cmd.start;
            end
         end
         ST_RD: begin
            state_in = ST_LD;
         end
         ST_LD: begin
            if (load) begin
               valid_in = 1'b1;
               byte_in  = cfg.common_cathode ? raw : ~raw;
               last_in  = e_ff == '0;
               tl_in    = (kind_ff == REQ_TEXT) && flag_ff;
               if (e_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RD;
                  e_in     = e_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      emit_busy         = state_ff != ST_IDLE;
      rsp_valid         = valid_ff;
      rsp_segment_byte  = byte_ff;
      rsp_last_digit    = last_ff;
      rsp_text_too_long = tl_ff;
   end

   always_ff @(posedge clock) begin
      if (frame_wr.en) begin
         frame_mem[frame_wr.addr] <= frame_wr.data;
      end
      rd_data_ff <= frame_mem[e_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      kind_ff  <= kind_in;
      flag_ff  <= flag_in;
      start_ff <= start_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      tl_ff    <= tl_in;
   end

   a_go_when_idle: assert property (@(posedge clock) disable iff (reset)
      emit_cmd.go |-> (state_ff == ST_IDLE))
      else $error("frame started while emitting");

   a_end_of_frame: assert property (@(posedge clock) disable iff (reset)
      (load && e_ff == '0) |=> (state_ff == ST_IDLE && rsp_valid && rsp_last_digit))
      else $error("frame did not close on digit zero");

   a_no_write_while_emit: assert property (@(posedge clock) disable iff (reset)
      frame_wr.en |-> (state_ff == ST_IDLE))
      else $error("frame memory written during emission");

endmodule

`default_nettype wire

@@ rtl/seven_segment_text_formatter_unit.sv @@
// Top level of the seven-segment text formatter.
`default_nettype none

// Text characters load one per cycle, while no justify walk or frame
// emission is under way, into a 16-entry text memory. A last character,
// unless the text is too long or all periods, starts a justify walk that
// reads that memory one character per cycle, writing digit bytes into an
// 8-entry frame memory. The frame is then sent from the highest digit
// down, each word by a frame memory read, then an output register load
// that waits while the output is stalled; clear and all-on frames follow
// the same steps. A new request is taken once the previous frame has been
// handed to the output register. Text longer than the digits, or than the
// buffer, yields a blank frame with text_too_long set on every word.
module seven_segment_text_formatter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_segment_byte,
   output logic             rsp_last_digit,
   output logic             rsp_text_too_long,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import sstf_pkg::*;

   cfg_type      cfg;
   emit_cmd_type emit_cmd;
   frame_wr_type frame_wr;
   logic         emit_busy;

   sstf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sstf_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .digits        (cfg.digits),
      .emit_busy     (emit_busy),
      .emit_cmd      (emit_cmd),
      .frame_wr      (frame_wr)
   );

   sstf_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .emit_cmd          (emit_cmd),
      .frame_wr          (frame_wr),
      .emit_busy         (emit_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_segment_byte  (rsp_segment_byte),
      .rsp_last_digit    (rsp_last_digit),
      .rsp_text_too_long (rsp_text_too_long)
   );

endmodule

`default_nettype wire
